// ===== src/tcmi_pkg.sv =====
// shared constants and types for the triclinic minimum-image core
package tcmi_pkg;

	// coordinate width default and fixed field widths
	localparam int COORD_WIDTH_DEF = 32;
	localparam int ENTRY_W         = 32;
	localparam int REG_W           = 64;
	localparam int CFG_IDX_W       = 3;

	// fixed-point layout: Q16.16 displacement, Q4.28 to-fractional matrix entry, Q.28 fractional coordinate
	localparam int DISP_FRAC = 16;
	localparam int FRAC_BITS = 28;
	localparam int W_W       = FRAC_BITS + 1;
	localparam int CP_W      = ENTRY_W + W_W;
	localparam int ACC_W     = 64;
	localparam int V_W       = ACC_W - FRAC_BITS;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TO_FRAC_A,
		REG_TO_FRAC_B,
		REG_TO_FRAC_C,
		REG_TO_CART_A,
		REG_TO_CART_B,
		REG_TO_CART_C
	} cfg_reg_e;

	// nonzero entries of an upper-triangular 3x3 matrix
	typedef struct packed {
		logic signed [ENTRY_W-1:0] m00;
		logic signed [ENTRY_W-1:0] m01;
		logic signed [ENTRY_W-1:0] m02;
		logic signed [ENTRY_W-1:0] m11;
		logic signed [ENTRY_W-1:0] m12;
		logic signed [ENTRY_W-1:0] m22;
	} tri_mat_t;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pipe_ld_t;

	// wrapped fractional coordinate, Q.28 in [-0.5, 0.5]
	typedef logic signed [W_W-1:0] frac_t;

	// rounded Cartesian value before saturation
	typedef logic signed [V_W-1:0] cart_t;

endpackage

// ===== src/tcmi_frac.sv =====
// fractional transform and minimum-image wrap, pipeline stages 1 to 4
module tcmi_frac import tcmi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  pipe_ld_t                      ld,
	input  tri_mat_t                      fmat,
	input  logic signed [COORD_WIDTH-1:0] disp_x,
	input  logic signed [COORD_WIDTH-1:0] disp_y,
	input  logic signed [COORD_WIDTH-1:0] disp_z,
	output frac_t                         wrap_x,
	output frac_t                         wrap_y,
	output frac_t                         wrap_z
);

	localparam int NPROD = 6;
	localparam int DH_W  = COORD_WIDTH + 1 - DISP_FRAC;
	localparam int DL_W  = DISP_FRAC + 1;
	localparam int PH_W  = ENTRY_W + DH_W;
	localparam int PL_W  = ENTRY_W + DL_W;
	localparam int PW    = ENTRY_W + COORD_WIDTH;
	localparam int SW    = PW + 2;

	logic signed [ENTRY_W-1:0]     f_ent [NPROD];
	logic signed [COORD_WIDTH-1:0] d_sel [NPROD];
	logic signed [PH_W-1:0]        ph_s1 [NPROD];
	logic signed [PL_W-1:0]        pl_s1 [NPROD];
	logic signed [PW-1:0]          p_s2  [NPROD];
	logic signed [SW-1:0]          sum0_s3, sum1_s3, sum2_s3;
	frac_t                         w0_s4, w1_s4, w2_s4;

	// wrap floor(s / 2^16) into [-0.5, 0.5]; an exact negative half
	// other than -0.5 itself goes to +0.5
	function automatic frac_t wrap_frac(input logic signed [SW-1:0] s);
		logic [FRAC_BITS-1:0] r;
		logic                 upper_ones;
		logic                 keep_pos;
		r          = s[FRAC_BITS+DISP_FRAC-1:DISP_FRAC];
		upper_ones = &s[SW-1:FRAC_BITS+DISP_FRAC];
		keep_pos   = !r[FRAC_BITS-1] ||
			(r[FRAC_BITS-2:0] == '0 && s[SW-1] && !upper_ones);
		wrap_frac  = keep_pos ? {1'b0, r} : {1'b1, r};
	endfunction

	// operand pairing of the six nonzero products
	always_comb begin
		f_ent[0] = fmat.m00;  d_sel[0] = disp_x;
		f_ent[1] = fmat.m01;  d_sel[1] = disp_y;
		f_ent[2] = fmat.m02;  d_sel[2] = disp_z;
		f_ent[3] = fmat.m11;  d_sel[3] = disp_y;
		f_ent[4] = fmat.m12;  d_sel[4] = disp_z;
		f_ent[5] = fmat.m22;  d_sel[5] = disp_z;
	end

	for (genvar gi = 0; gi < NPROD; gi++) begin : g_prod
		logic signed [COORD_WIDTH:0] d_ext;
		logic signed [DH_W-1:0]      d_hi;
		logic signed [DL_W-1:0]      d_lo;

		// split the displacement into a signed high part and unsigned low half-word
		assign d_ext = {d_sel[gi][COORD_WIDTH-1], d_sel[gi]};
		assign d_hi  = d_ext[COORD_WIDTH:DISP_FRAC];
		assign d_lo  = {1'b0, d_ext[DISP_FRAC-1:0]};

		// stage 1: partial products
		always_ff @(posedge clk) begin
			if (ld.s1) begin
				ph_s1[gi] <= f_ent[gi] * d_hi;
				pl_s1[gi] <= f_ent[gi] * d_lo;
			end
		end

		// stage 2: recombine into the full Q.44 product
		always_ff @(posedge clk) begin
			if (ld.s2) begin
				p_s2[gi] <= (PW'(ph_s1[gi]) <<< DISP_FRAC) + PW'(pl_s1[gi]);
			end
		end
	end

	// stage 3: row sums of the upper-triangular product
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			sum0_s3 <= SW'(p_s2[0]) + SW'(p_s2[1]) + SW'(p_s2[2]);
			sum1_s3 <= SW'(p_s2[3]) + SW'(p_s2[4]);
			sum2_s3 <= SW'(p_s2[5]);
		end
	end

	// stage 4: minimum-image wrap
	always_ff @(posedge clk) begin
		if (ld.s4) begin
			w0_s4 <= wrap_frac(sum0_s3);
			w1_s4 <= wrap_frac(sum1_s3);
			w2_s4 <= wrap_frac(sum2_s3);
		end
	end

	assign wrap_x = w0_s4;
	assign wrap_y = w1_s4;
	assign wrap_z = w2_s4;

endmodule

// ===== src/tcmi_cart.sv =====
// back-transform to Cartesian with rounding, pipeline stages 5 and 6
module tcmi_cart import tcmi_pkg::*; (
	input  logic     clk,
	input  pipe_ld_t ld,
	input  tri_mat_t cmat,
	input  frac_t    wrap_x,
	input  frac_t    wrap_y,
	input  frac_t    wrap_z,
	output cart_t    cart_x,
	output cart_t    cart_y,
	output cart_t    cart_z
);

	localparam int NPROD = 6;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	logic signed [CP_W-1:0] cp_s5 [NPROD];
	cart_t                  v0_s6, v1_s6, v2_s6;
	logic signed [ACC_W-1:0] acc0, acc1, acc2;

	// stage 5: matrix times wrapped vector products
	always_ff @(posedge clk) begin
		if (ld.s5) begin
			cp_s5[0] <= cmat.m00 * wrap_x;
			cp_s5[1] <= cmat.m01 * wrap_y;
			cp_s5[2] <= cmat.m02 * wrap_z;
			cp_s5[3] <= cmat.m11 * wrap_y;
			cp_s5[4] <= cmat.m12 * wrap_z;
			cp_s5[5] <= cmat.m22 * wrap_z;
		end
	end

	// row sums plus half an lsb, halves round toward +infinity
	always_comb begin
		acc0 = ACC_W'(cp_s5[0]) + ACC_W'(cp_s5[1]) + ACC_W'(cp_s5[2]) + ROUND_HALF;
		acc1 = ACC_W'(cp_s5[3]) + ACC_W'(cp_s5[4]) + ROUND_HALF;
		acc2 = ACC_W'(cp_s5[5]) + ROUND_HALF;
	end

	// stage 6: drop the fractional bits (floor)
	always_ff @(posedge clk) begin
		if (ld.s6) begin
			v0_s6 <= acc0[ACC_W-1:FRAC_BITS];
			v1_s6 <= acc1[ACC_W-1:FRAC_BITS];
			v2_s6 <= acc2[ACC_W-1:FRAC_BITS];
		end
	end

	assign cart_x = v0_s6;
	assign cart_y = v1_s6;
	assign cart_z = v2_s6;

endmodule

// ===== src/triclinic_minimum_image_core.sv =====
// top level of the triclinic minimum-image core: config, flow control, output stage
//
// Wraps one Q16.16 displacement per beat into the minimum image of a triclinic
// box: fractional transform (Q4.28), wrap of each component into [-0.5, 0.5],
// back-transform and saturation to COORD_WIDTH bits. Throughput is one beat per
// cycle while out_stall is low. A beat passes through seven register stages
// (two for the split fractional multiply, row sum, wrap, Cartesian multiply,
// round, saturate into the output register). Each stage has its own valid bit
// and loads when it is empty or its successor moves, so bubbles are squeezed
// out under out_stall and input is taken while a result waits. Matrix registers
// are to be written through the cfg port only while idle; the block itself
// does not enforce this.
module triclinic_minimum_image_core import tcmi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [REG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] disp_x,
	input  logic signed [COORD_WIDTH-1:0] disp_y,
	input  logic signed [COORD_WIDTH-1:0] disp_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] image_x,
	output logic signed [COORD_WIDTH-1:0] image_y,
	output logic signed [COORD_WIDTH-1:0] image_z
);

	localparam int EW = (COORD_WIDTH > V_W) ? COORD_WIDTH : V_W;
	localparam logic signed [EW-1:0] SAT_HI =
		{{(EW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

	logic [REG_W-1:0] to_frac_a_q, to_frac_b_q, to_frac_c_q;
	logic [REG_W-1:0] to_cart_a_q, to_cart_b_q, to_cart_c_q;
	tri_mat_t         fmat, cmat;
	pipe_ld_t         ld;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	frac_t            wrap_x, wrap_y, wrap_z;
	cart_t            cart_x, cart_y, cart_z;
	logic signed [COORD_WIDTH-1:0] img_x_s7, img_y_s7, img_z_s7;

	// clamp a rounded value to the coordinate range
	function automatic logic signed [COORD_WIDTH-1:0] sat(input cart_t v);
		logic signed [EW-1:0] vx;
		vx = EW'(v);
		if (vx > SAT_HI) begin
			vx = SAT_HI;
		end else if (vx < SAT_LO) begin
			vx = SAT_LO;
		end
		sat = vx[COORD_WIDTH-1:0];
	endfunction

	// matrix registers; writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			to_frac_a_q <= '0;
			to_frac_b_q <= '0;
			to_frac_c_q <= '0;
			to_cart_a_q <= '0;
			to_cart_b_q <= '0;
			to_cart_c_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_e'(cfg_index))
				REG_TO_FRAC_A: to_frac_a_q <= cfg_data;
				REG_TO_FRAC_B: to_frac_b_q <= cfg_data;
				REG_TO_FRAC_C: to_frac_c_q <= cfg_data;
				REG_TO_CART_A: to_cart_a_q <= cfg_data;
				REG_TO_CART_B: to_cart_b_q <= cfg_data;
				REG_TO_CART_C: to_cart_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack matrix entries, first entry in the low word
	always_comb begin
		fmat.m00 = to_frac_a_q[ENTRY_W-1:0];
		fmat.m01 = to_frac_a_q[REG_W-1:ENTRY_W];
		fmat.m02 = to_frac_b_q[ENTRY_W-1:0];
		fmat.m11 = to_frac_b_q[REG_W-1:ENTRY_W];
		fmat.m12 = to_frac_c_q[ENTRY_W-1:0];
		fmat.m22 = to_frac_c_q[REG_W-1:ENTRY_W];
		cmat.m00 = to_cart_a_q[ENTRY_W-1:0];
		cmat.m01 = to_cart_a_q[REG_W-1:ENTRY_W];
		cmat.m02 = to_cart_b_q[ENTRY_W-1:0];
		cmat.m11 = to_cart_b_q[REG_W-1:ENTRY_W];
		cmat.m12 = to_cart_c_q[ENTRY_W-1:0];
		cmat.m22 = to_cart_c_q[REG_W-1:ENTRY_W];
	end

	// stage loads: a stage moves when empty or when the next one moves
	always_comb begin
		ld.s7 = !vld_s7 || !out_stall;
		ld.s6 = !vld_s6 || ld.s7;
		ld.s5 = !vld_s5 || ld.s6;
		ld.s4 = !vld_s4 || ld.s5;
		ld.s3 = !vld_s3 || ld.s4;
		ld.s2 = !vld_s2 || ld.s3;
		ld.s1 = !vld_s1 || ld.s2;
	end

	assign in_stall = !ld.s1;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (ld.s1) vld_s1 <= in_valid;
			if (ld.s2) vld_s2 <= vld_s1;
			if (ld.s3) vld_s3 <= vld_s2;
			if (ld.s4) vld_s4 <= vld_s3;
			if (ld.s5) vld_s5 <= vld_s4;
			if (ld.s6) vld_s6 <= vld_s5;
			if (ld.s7) vld_s7 <= vld_s6;
		end
	end

	// fractional transform and wrap
	tcmi_frac #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_frac (
		.clk    (clk),
		.ld     (ld),
		.fmat   (fmat),
		.disp_x (disp_x),
		.disp_y (disp_y),
		.disp_z (disp_z),
		.wrap_x (wrap_x),
		.wrap_y (wrap_y),
		.wrap_z (wrap_z)
	);

	// back-transform and rounding
	tcmi_cart u_cart (
		.clk    (clk),
		.ld     (ld),
		.cmat   (cmat),
		.wrap_x (wrap_x),
		.wrap_y (wrap_y),
		.wrap_z (wrap_z),
		.cart_x (cart_x),
		.cart_y (cart_y),
		.cart_z (cart_z)
	);

	// stage 7: saturate into the output register
	always_ff @(posedge clk) begin
		if (ld.s7) begin
			img_x_s7 <= sat(cart_x);
			img_y_s7 <= sat(cart_y);
			img_z_s7 <= sat(cart_z);
		end
	end

	assign out_valid = vld_s7;
	assign image_x   = img_x_s7;
	assign image_y   = img_y_s7;
	assign image_z   = img_z_s7;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for the triclinic minimum-image core: predictor, driver, monitor
module testbench;
	import tcmi_pkg::*;

	localparam int CW              = COORD_WIDTH_DEF;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int RAND_PHASES     = 16;
	localparam int SQUEEZE_ITEMS   = 60;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 12;
	localparam int CYCLE_LIMIT     = 200000;

	// fixed-point constants
	localparam logic signed [ENTRY_W-1:0] ONE_Q28   = 32'sh1000_0000;
	localparam logic signed [ENTRY_W-1:0] ONE_Q16   = 32'sh0001_0000;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 32'sh7fff_ffff;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 32'sh8000_0000;
	localparam logic signed [CW-1:0]      HALF_BOX  = 32'sh0000_8000;
	localparam logic signed [CW-1:0]      COORD_TOP = 32'sh7fff_ffff;
	localparam logic signed [CW-1:0]      COORD_BOT = 32'sh8000_0000;
	localparam longint HALF_Q28  = 64'sd1 <<< (FRAC_BITS - 1);
	localparam longint WHOLE_Q28 = 64'sd1 <<< FRAC_BITS;
	localparam longint SAT_HI    = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint SAT_LO    = -SAT_HI - 1;
	localparam logic signed [95:0] NEG_HALF_WIDE = -(96'sd1 <<< (FRAC_BITS - 1));

	// config indices past the register map
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

	typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_e;
	typedef enum {MK_BOX, MK_UNIT, MK_WILD, MK_EDGE} mat_kind_e;
	typedef enum {CK_NEAR, CK_HALF, CK_WILD, CK_EDGE} coord_kind_e;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} vec3_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [REG_W-1:0]       cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic signed [CW-1:0]   disp_x    = '0;
	logic signed [CW-1:0]   disp_y    = '0;
	logic signed [CW-1:0]   disp_z    = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [CW-1:0]   image_x;
	logic signed [CW-1:0]   image_y;
	logic signed [CW-1:0]   image_z;

	// shadow of the matrix registers
	tri_mat_t frac_mat = '0;
	tri_mat_t cart_mat = '0;

	vec3_t       disp_backlog[$];
	vec3_t       image_due[$];
	gap_mode_e   gap_mode     = GAP_NONE;
	logic        in_beat      = 1'b0;
	logic        rx_hold      = 1'b0;
	logic        squeeze_req  = 1'b0;
	int unsigned cycle_count  = 0;
	int          beats_in     = 0;
	int          beats_out    = 0;
	int          mismatches   = 0;
	int          stall_cycles = 0;
	int          matrix_loads = 0;

	triclinic_minimum_image_core #(.COORD_WIDTH(CW)) i_dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .disp_x, .disp_y, .disp_z,
		.out_valid, .out_stall, .image_x, .image_y, .image_z
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("triclinic_minimum_image_core regression: fail");
			$finish;
		end
	end

	// exact product of two signed entries
	function automatic logic signed [95:0] wide_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [95:0] wa, wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// fractional coordinate taken to Q.28 and wrapped into [-0.5, 0.5]
	function automatic frac_t wrap_coord(input logic signed [95:0] s);
		logic signed [95:0] f;
		longint r;
		f = s >>> DISP_FRAC;
		r = 0;
		r[FRAC_BITS-1:0] = f[FRAC_BITS-1:0];
		if (r < HALF_Q28)
			return frac_t'(r);
		// a negative half below -0.5 goes up to +0.5, -0.5 itself stays
		if (r == HALF_Q28 && s[95] && f != NEG_HALF_WIDE)
			return frac_t'(r);
		return frac_t'(r - WHOLE_Q28);
	endfunction

	function automatic longint cart_term(input logic signed [ENTRY_W-1:0] c, input frac_t w);
		return longint'(c) * longint'(w);
	endfunction

	// round half up to Q16.16, then clamp to the coordinate width
	function automatic logic signed [CW-1:0] round_sat(input longint acc);
		longint v;
		v = (acc + HALF_Q28) >>> FRAC_BITS;
		if (v > SAT_HI)
			v = SAT_HI;
		else if (v < SAT_LO)
			v = SAT_LO;
		return v[CW-1:0];
	endfunction

	// expected image of one displacement under the current matrices
	function automatic vec3_t wrap_image(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
		frac_t wx, wy, wz;
		vec3_t img;
		wx = wrap_coord(wide_mul(frac_mat.m00, x) + wide_mul(frac_mat.m01, y)
			+ wide_mul(frac_mat.m02, z));
		wy = wrap_coord(wide_mul(frac_mat.m11, y) + wide_mul(frac_mat.m12, z));
		wz = wrap_coord(wide_mul(frac_mat.m22, z));
		img.x = round_sat(cart_term(cart_mat.m00, wx) + cart_term(cart_mat.m01, wy)
			+ cart_term(cart_mat.m02, wz));
		img.y = round_sat(cart_term(cart_mat.m11, wy) + cart_term(cart_mat.m12, wz));
		img.z = round_sat(cart_term(cart_mat.m22, wz));
		return img;
	endfunction

	function automatic int gap_pct(input bit rx_side);
		case (gap_mode)
			GAP_SEND: return rx_side ? 0 : 61;
			GAP_RECV: return rx_side ? 61 : 0;
			GAP_BOTH: return 23;
			default:  return 0;
		endcase
	endfunction

	// input driver: next beat offered once the current one is taken
	always @(negedge clk) begin : driver
		vec3_t next_disp;
		bit offer;
		if (!in_valid || in_beat) begin
			offer = disp_backlog.size() != 0 && $urandom_range(99) >= gap_pct(1'b0);
			if (offer) begin
				next_disp = disp_backlog.pop_front();
				disp_x <= next_disp.x;
				disp_y <= next_disp.y;
				disp_z <= next_disp.z;
			end
			in_valid <= offer;
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		out_stall <= rx_hold || $urandom_range(99) < gap_pct(1'b1);
	end

	// long hold-off on the output so the pipeline fills and stalls its input
	initial begin : back_pressure
		wait (squeeze_req);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// monitor: predict on input beats, check output beats in order
	always @(posedge clk) begin : monitor
		vec3_t got, want;
		in_beat <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				image_due.push_back(wrap_image(disp_x, disp_y, disp_z));
				beats_in++;
			end
			if (in_valid && in_stall)
				stall_cycles++;
			if (out_valid && !out_stall) begin
				got = '{image_x, image_y, image_z};
				beats_out++;
				if (image_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result (%0d, %0d, %0d)", got.x, got.y, got.z);
					mismatches++;
				end else begin
					want = image_due.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
						if (mismatches < 10)
							$display("result %0d: expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
								beats_out, want.x, want.y, want.z, got.x, got.y, got.z);
						mismatches++;
					end
				end
			end
		end
	end

	// register write, mirrored into the shadow
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		case (idx)
			REG_TO_FRAC_A: {frac_mat.m01, frac_mat.m00} = data;
			REG_TO_FRAC_B: {frac_mat.m11, frac_mat.m02} = data;
			REG_TO_FRAC_C: {frac_mat.m22, frac_mat.m12} = data;
			REG_TO_CART_A: {cart_mat.m01, cart_mat.m00} = data;
			REG_TO_CART_B: {cart_mat.m11, cart_mat.m02} = data;
			REG_TO_CART_C: {cart_mat.m22, cart_mat.m12} = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic load_matrices(input tri_mat_t fm, input tri_mat_t cm);
		write_reg(REG_TO_FRAC_A, {fm.m01, fm.m00});
		write_reg(REG_TO_FRAC_B, {fm.m11, fm.m02});
		write_reg(REG_TO_FRAC_C, {fm.m22, fm.m12});
		write_reg(REG_TO_CART_A, {cm.m01, cm.m00});
		write_reg(REG_TO_CART_B, {cm.m11, cm.m02});
		write_reg(REG_TO_CART_C, {cm.m22, cm.m12});
		matrix_loads++;
	endtask

	function automatic tri_mat_t unit_matrix(input logic signed [ENTRY_W-1:0] one);
		tri_mat_t m;
		m = '0;
		m.m00 = one;
		m.m11 = one;
		m.m22 = one;
		return m;
	endfunction

	function automatic logic [ENTRY_W-1:0] draw_entry(input mat_kind_e kind, input bit diag,
			input bit frac);
		case (kind)
			// realistic box: cell lengths of a few to some tens of units
			MK_BOX:
				if (frac)
					return diag ? $urandom_range(1 << 27, 1 << 22)
						: $urandom_range(1 << 23, 0) - (1 << 22);
				else
					return diag ? $urandom_range(1 << 22, 1 << 17)
						: $urandom_range(1 << 21, 0) - (1 << 20);
			// unit box with half-cell tilts, so exact halves occur
			MK_UNIT:
				if (frac)
					return diag ? ONE_Q28 : ($urandom_range(2, 0) - 1) * (1 << 27);
				else
					return diag ? ONE_Q16 : $urandom_range(1 << 17, 0) - (1 << 16);
			MK_WILD:
				return $urandom;
			default:
				case ($urandom_range(4, 0))
					0:       return ENTRY_MAX;
					1:       return ENTRY_MIN;
					2:       return '0;
					3:       return 32'sd1;
					default: return -32'sd1;
				endcase
		endcase
	endfunction

	function automatic tri_mat_t draw_matrix(input mat_kind_e kind, input bit frac);
		tri_mat_t m;
		m.m00 = draw_entry(kind, 1'b1, frac);
		m.m01 = draw_entry(kind, 1'b0, frac);
		m.m02 = draw_entry(kind, 1'b0, frac);
		m.m11 = draw_entry(kind, 1'b1, frac);
		m.m12 = draw_entry(kind, 1'b0, frac);
		m.m22 = draw_entry(kind, 1'b1, frac);
		return m;
	endfunction

	function automatic logic [CW-1:0] draw_coord(input coord_kind_e kind);
		case (kind)
			CK_NEAR: return $urandom_range(1 << 23, 0) - (1 << 22);
			CK_HALF: return ($urandom_range(32, 0) - 16) << 15;
			CK_WILD: return $urandom;
			default:
				case ($urandom_range(6, 0))
					0:       return COORD_TOP;
					1:       return COORD_BOT;
					2:       return '0;
					3:       return -32'sd1;
					4:       return 32'sd1;
					5:       return HALF_BOX;
					default: return -HALF_BOX;
				endcase
		endcase
	endfunction

	function automatic vec3_t draw_disp();
		coord_kind_e kind;
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 45)
			kind = CK_NEAR;
		else if (roll < 65)
			kind = CK_HALF;
		else if (roll < 90)
			kind = CK_WILD;
		else
			kind = CK_EDGE;
		return '{draw_coord(kind), draw_coord(kind), draw_coord(kind)};
	endfunction

	task automatic queue_disp(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z);
		disp_backlog.push_back('{x, y, z});
	endtask

	// wait for every queued beat to come back, then let the pipeline settle
	task automatic wait_drained();
		while (disp_backlog.size() != 0 || in_valid || image_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		mat_kind_e mk;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// registers at reset: every image is zero
		queue_disp('0, '0, '0);
		queue_disp(COORD_TOP, COORD_TOP, COORD_TOP);
		queue_disp(COORD_BOT, COORD_BOT, COORD_BOT);
		queue_disp(32'sd1, -32'sd1, HALF_BOX);
		wait_drained();

		// unit box: halves, negative halves and wraps of several cells
		load_matrices(unit_matrix(ONE_Q28), unit_matrix(ONE_Q16));
		queue_disp(HALF_BOX, -HALF_BOX, -3 * HALF_BOX);
		queue_disp(3 * HALF_BOX, 5 * HALF_BOX, -5 * HALF_BOX);
		queue_disp(HALF_BOX - 1, -HALF_BOX - 1, HALF_BOX + 1);
		queue_disp(COORD_TOP, COORD_BOT, -32'sd1);
		queue_disp(-HALF_BOX, -3 * HALF_BOX, HALF_BOX);
		queue_disp(ONE_Q16, -ONE_Q16, '0);
		wait_drained();

		// saturation both ways through the largest Cartesian entries
		load_matrices(unit_matrix(ONE_Q28), {6{ENTRY_MAX}});
		queue_disp(-3 * HALF_BOX, -3 * HALF_BOX, -3 * HALF_BOX);
		queue_disp(HALF_BOX, HALF_BOX, HALF_BOX);
		wait_drained();
		load_matrices(unit_matrix(ONE_Q28), {6{ENTRY_MIN}});
		queue_disp(-3 * HALF_BOX, -3 * HALF_BOX, -3 * HALF_BOX);
		queue_disp(HALF_BOX, HALF_BOX, HALF_BOX);
		wait_drained();

		// extreme fractional entries against extreme displacements
		load_matrices({6{ENTRY_MAX}}, unit_matrix(ONE_Q16));
		queue_disp(COORD_TOP, COORD_TOP, COORD_TOP);
		queue_disp(COORD_BOT, COORD_BOT, COORD_BOT);
		wait_drained();
		load_matrices({6{ENTRY_MIN}}, unit_matrix(ONE_Q16));
		queue_disp(COORD_TOP, COORD_TOP, COORD_TOP);
		queue_disp(COORD_BOT, COORD_BOT, COORD_BOT);
		wait_drained();

		// writes past the register map leave the matrices alone
		load_matrices(unit_matrix(ONE_Q28), unit_matrix(ONE_Q16));
		write_reg(CFG_IDX_SPARE_A, {$urandom, $urandom});
		write_reg(CFG_IDX_SPARE_B, {$urandom, $urandom});
		queue_disp(HALF_BOX, -3 * HALF_BOX, 32'sd7);
		wait_drained();

		// random phases over matrix kinds and idling patterns
		for (int p = 0; p < RAND_PHASES; p++) begin
			mk = mat_kind_e'(p % 4);
			load_matrices(draw_matrix(mk, 1'b1), draw_matrix(mk, 1'b0));
			if (p % 5 == 2)
				write_reg(p % 2 ? CFG_IDX_SPARE_B : CFG_IDX_SPARE_A, {$urandom, $urandom});
			gap_mode = gap_mode_e'((p + p / 4) % 4);
			repeat (ITEMS_PER_PHASE) disp_backlog.push_back(draw_disp());
			wait_drained();
		end

		// long output hold-off with a steady input stream
		load_matrices(draw_matrix(MK_BOX, 1'b1), draw_matrix(MK_BOX, 1'b0));
		gap_mode = GAP_NONE;
		squeeze_req = 1'b1;
		repeat (SQUEEZE_ITEMS) disp_backlog.push_back(draw_disp());
		wait_drained();

		if (image_due.size() != 0)
			$display("%0d images still outstanding at end of run", image_due.size());
		$display("%0d displacements sent, %0d images checked over %0d matrix loads",
			beats_in, beats_out, matrix_loads);
		$display("input held off for %0d cycles, %0d mismatches", stall_cycles, mismatches);
		if (mismatches == 0 && image_due.size() == 0)
			$display("triclinic_minimum_image_core regression: pass");
		else
			$display("triclinic_minimum_image_core regression: fail");
		$finish;
	end

endmodule
